// File: rtl/flm_pkg.sv
// shared types and constants of the flash logical block map
package flm_pkg;

  localparam int unsigned BlockW = 13;
  localparam int unsigned PageW  = 18;
  localparam int unsigned OffW   = 5;
  localparam int unsigned CountW = 14;
  localparam int unsigned EntryW = BlockW + 1;

  // operation codes
  localparam logic [1:0] OpClear     = 2'd0;
  localparam logic [1:0] OpScan      = 2'd1;
  localparam logic [1:0] OpTranslate = 2'd2;

  // scan status codes
  localparam logic [1:0] StatMapped   = 2'd0;
  localparam logic [1:0] StatErased   = 2'd1;
  localparam logic [1:0] StatReserved = 2'd2;
  localparam logic [1:0] StatIgnored  = 2'd3;

  // spare area markers
  localparam logic [7:0] SpareBlank = 8'hFF;
  localparam logic [7:0] FlagMask   = 8'hF8;
  localparam logic [7:0] FlagMatch  = 8'h10;

  localparam logic [BlockW-1:0] ZoneBlocks = 13'd1000;

  localparam logic [2:0] AddrCycNarrow = 3'd3;
  localparam logic [2:0] AddrCycWide   = 3'd4;

  // scan decode result
  typedef struct packed {
    logic              wr;
    logic [1:0]        status;
    logic [BlockW-1:0] lblock;
  } scan_res_t;

  // one result item
  typedef struct packed {
    logic [1:0]        status;
    logic [BlockW-1:0] lblock;
    logic              mapped;
    logic [PageW-1:0]  ppage;
    logic [2:0]        acyc;
  } rsp_t;

endpackage

// File: rtl/flm_ram.sv
// generic single-port ram with registered read
module flm_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/flm_scan.sv
// spare area decode of one scanned physical block
module flm_scan #(
  parameter int unsigned MAP_ENTRIES = 8192
) (
  input  logic [12:0]         physical_block_i,
  input  logic [63:0]         spare_low_i,
  input  logic [63:0]         spare_high_i,
  input  logic [13:0]         block_count_i,
  output flm_pkg::scan_res_t  scan_o
);
  import flm_pkg::*;

  localparam logic [CountW-1:0] MapEntriesW = CountW'(MAP_ENTRIES);

  logic [7:0]        b5, b6, b7;
  logic [9:0]        lfield;
  logic [2:0]        zone;
  logic [BlockW-1:0] lblock;
  logic              tagged_blk;
  logic              blank;

  assign b5     = spare_low_i[47:40];
  assign b6     = spare_low_i[55:48];
  assign b7     = spare_low_i[63:56];
  // bits 10:1 of the byte6:byte7 address word
  assign lfield = {b6[2:0], b7[7:1]};
  assign zone   = physical_block_i[12:10];
  assign lblock = BlockW'(lfield) + BlockW'(zone) * ZoneBlocks;

  assign tagged_blk = (b5 == SpareBlank) && ((b6 & FlagMask) == FlagMatch);
  assign blank      = (spare_low_i == '1) && (spare_high_i == '1);

  always_comb begin
    scan_o = '0;
    if ({1'b0, physical_block_i} >= block_count_i) begin
      scan_o.status = StatIgnored;
    end else if (tagged_blk) begin
      if ({1'b0, lblock} >= MapEntriesW) begin
        scan_o.status = StatIgnored;
      end else begin
        scan_o.wr     = 1'b1;
        scan_o.status = StatMapped;
        scan_o.lblock = lblock;
      end
    end else if (blank) begin
      scan_o.status = StatErased;
    end else begin
      scan_o.status = StatReserved;
    end
  end

endmodule

// File: rtl/flash_logical_block_map.sv
// top level of the flash logical-to-physical block map
//
// keeps one map entry per logical block (valid flag and physical block)
// in a single-port synchronous ram of MAP_ENTRIES words
// input channel (in_valid_i/in_ready_o) takes one operation per transfer:
//   clear     - marks every logical block unmapped
//   scan      - classifies a physical block from its 16 spare bytes and
//               records the mapping when the block carries an address
//   translate - turns a logical page into a physical page
// output channel (out_valid_o/out_ready_i) gives one result per operation
// the one ram port is used by one item at a time, in these steps:
//   scan writes its entry on accept, translate reads its entry and takes it in
//   ST_READ (registered ram read), clear sweeps the ram one entry a cycle; all end in ST_DONE
// after reset the same sweep over all MAP_ENTRIES entries runs, with in_ready_o
// low; configuration writes are taken during it
// a result waiting on a stalled receiver sits in the output register while
// the next item is accepted and worked on; the pending result then waits
// until the output register frees up
// config: index 0 block_count, index 1 wide_address, written any cycle
module flash_logical_block_map #(
  parameter int unsigned MAP_ENTRIES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [13:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [12:0] physical_block_i,
  input  logic [63:0] spare_low_i,
  input  logic [63:0] spare_high_i,
  input  logic [17:0] logical_page_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  block_status_o,
  output logic [12:0] logical_block_o,
  output logic        mapped_o,
  output logic [17:0] physical_page_o,
  output logic [2:0]  address_cycles_o
);
  import flm_pkg::*;

  localparam int unsigned AW = $clog2(MAP_ENTRIES);
  localparam logic [AW-1:0]     LastEntry   = AW'(MAP_ENTRIES - 1);
  localparam logic [CountW-1:0] MapEntriesW = CountW'(MAP_ENTRIES);

  localparam logic [0:0] CfgBlockCount  = 1'b0;
  localparam logic [0:0] CfgWideAddress = 1'b1;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      cnt_q, cnt_d;
  logic               clr_rsp_q, clr_rsp_d;   // sweep was started by a clear
  logic               rng_q, rng_d;           // translate index inside the map
  logic [OffW-1:0]    off_q, off_d;           // page offset of a translate
  rsp_t               res_q, res_d;           // pending result
  rsp_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [CountW-1:0]  block_count_q;
  logic               wide_q;

  // ram port
  logic               mem_en, mem_we;
  logic [AW-1:0]      mem_addr;
  logic [EntryW-1:0]  mem_wdata, mem_rdata;

  scan_res_t          scan;
  logic [BlockW-1:0]  tr_lblock;
  logic               tr_in_range;
  logic [2:0]         acyc;

  flm_scan #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_scan (
    .physical_block_i (physical_block_i),
    .spare_low_i      (spare_low_i),
    .spare_high_i     (spare_high_i),
    .block_count_i    (block_count_q),
    .scan_o           (scan)
  );

  flm_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAP_ENTRIES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // logical block of a translate is the page number without its offset
  assign tr_lblock   = logical_page_i[PageW-1:OffW];
  assign tr_in_range = {1'b0, tr_lblock} < MapEntriesW;
  assign acyc        = wide_q ? AddrCycWide : AddrCycNarrow;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_rsp_d   = clr_rsp_q;
    rng_d       = rng_q;
    off_d       = off_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = '0;
    mem_wdata   = '0;

    unique case (state_q)
      ST_SWEEP: begin
        // write an unmapped entry each cycle
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = cnt_q;
        if (cnt_q == LastEntry) begin
          cnt_d     = '0;
          clr_rsp_d = 1'b0;
          state_d   = clr_rsp_q ? ST_DONE : ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d      = '0;
          res_d.acyc = acyc;
          unique case (operation_i)
            OpClear: begin
              clr_rsp_d = 1'b1;
              state_d   = ST_SWEEP;
            end
            OpScan: begin
              res_d.status = scan.status;
              res_d.lblock = scan.lblock;
              mem_en       = scan.wr;
              mem_we       = 1'b1;
              mem_addr     = scan.lblock[AW-1:0];
              mem_wdata    = {1'b1, physical_block_i};
              state_d      = ST_DONE;
            end
            OpTranslate: begin
              rng_d    = tr_in_range;
              off_d    = logical_page_i[OffW-1:0];
              mem_en   = tr_in_range;
              mem_addr = tr_lblock[AW-1:0];
              state_d  = ST_READ;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        // entry word is {valid, physical block}
        res_d.mapped = rng_q && mem_rdata[EntryW-1];
        res_d.ppage  = (rng_q && mem_rdata[EntryW-1]) ?
                       {mem_rdata[BlockW-1:0], off_q} : '0;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      cnt_q         <= '0;
      clr_rsp_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      block_count_q <= '0;
      wide_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_rsp_q   <= clr_rsp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgBlockCount:  block_count_q <= cfg_wdata_i;
          CfgWideAddress: wide_q        <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rng_q <= rng_d;
    off_q <= off_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign block_status_o   = out_q.status;
  assign logical_block_o  = out_q.lblock;
  assign mapped_o         = out_q.mapped;
  assign physical_page_o  = out_q.ppage;
  assign address_cycles_o = out_q.acyc;

endmodule

// File: rtl/flm_checker.sv
// port-level assertions for the flash logical block map, with bind
module flm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  block_status_o,
  input logic [12:0] logical_block_o,
  input logic        mapped_o,
  input logic [17:0] physical_page_o,
  input logic [2:0]  address_cycles_o
);
  import flm_pkg::*;

  // a result stays offered until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // one item at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on back to back cycles");

  // address cycle count is three or four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (address_cycles_o == AddrCycNarrow ||
                     address_cycles_o == AddrCycWide))
    else $error("bad address cycle count");

  // unmapped results, translate results among them, carry no page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mapped_o |-> physical_page_o == '0)
    else $error("page given for unmapped result");

  // scan results and translate results never mix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (block_status_o != StatMapped || logical_block_o != '0)
      |-> !mapped_o)
    else $error("scan result carries a mapping");

endmodule

bind flash_logical_block_map flm_checker u_flm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .block_status_o   (block_status_o),
  .logical_block_o  (logical_block_o),
  .mapped_o         (mapped_o),
  .physical_page_o  (physical_page_o),
  .address_cycles_o (address_cycles_o)
);
